>>> sv/wppm_pkg.sv
// Package for the window peak-to-peak meter.
// Holds the store geometry, the field types and the opcode names.
// No dependencies; every other file of the block uses it.
`timescale 1ns / 1ps
`default_nettype none

package wppm_pkg;

  // Depth of the sample ring store (a power of two, slots wrap by masking).
  localparam int unsigned STORE_DEPTH = 128;
  localparam int unsigned SLOT_W      = $clog2(STORE_DEPTH);
  // A count of samples must be able to hold the depth itself.
  localparam int unsigned COUNT_W     = $clog2(STORE_DEPTH + 1);

  localparam int unsigned POS_W    = 7;
  localparam int unsigned SAMPLE_W = 8;
  localparam int unsigned LEN_W    = 8;

  // Window length after reset.
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(32);

  typedef logic [SLOT_W-1:0]   slot_t;
  typedef logic [COUNT_W-1:0]  count_t;
  typedef logic [POS_W-1:0]    pos_t;
  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [LEN_W-1:0]    len_t;

  // Item opcodes.
  localparam logic OP_WRITE   = 1'b0;
  localparam logic OP_MEASURE = 1'b1;

endpackage : wppm_pkg

`default_nettype wire

>>> sv/wppm_if.sv
// Channel interfaces of the window peak-to-peak meter: item input,
// result output and configuration write. Depends on wppm_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Input items: a sample write or a window measurement.
interface wppm_in_if;
  logic               valid;
  logic               ready;
  logic               opcode;
  wppm_pkg::pos_t     position;
  wppm_pkg::sample_t  sample_value;

  modport source (output valid, output opcode, output position, output sample_value,
                  input ready);
  modport sink   (input valid, input opcode, input position, input sample_value,
                  output ready);
endinterface : wppm_in_if

// Result items of a measurement.
interface wppm_out_if;
  logic               valid;
  logic               ready;
  wppm_pkg::sample_t  min_level;
  wppm_pkg::sample_t  max_level;
  wppm_pkg::sample_t  spread;

  modport source (output valid, output min_level, output max_level, output spread,
                  input ready);
  modport sink   (input valid, input min_level, input max_level, input spread,
                  output ready);
endinterface : wppm_out_if

// Configuration write of the window length.
interface wppm_cfg_if;
  logic            valid;
  logic            ready;
  wppm_pkg::len_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface : wppm_cfg_if

`default_nettype wire

>>> sv/window_peak_to_peak_meter_unit.sv
// Window peak-to-peak meter: ring store of samples with min/max scan.
// Depends on wppm_pkg and the interfaces in wppm_if.sv.
// A write transfer gives no result; a new item is taken next cycle.
// A measure over L samples (window length, 0 read as 1, clipped to the depth) makes one memory
// read per slot and registers its result once the output is free; the next item is taken then.
// Reset clears the store through per-slot valid bits at once and sets the length to 32.
`timescale 1ns / 1ps
`default_nettype none

module window_peak_to_peak_meter_unit (
  input  wire               clk_i,
  input  wire               rst_ni,
  wppm_in_if.sink           in_i,
  wppm_cfg_if.sink          cfg_i,
  wppm_out_if.source        out_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e                         state_q;
  wppm_pkg::len_t                 window_len_q;
  logic [wppm_pkg::STORE_DEPTH-1:0] written_q;

  wppm_pkg::sample_t              sample_mem [wppm_pkg::STORE_DEPTH];
  wppm_pkg::sample_t              rdata_q;
  logic                           rwritten_q;

  wppm_pkg::slot_t                rd_addr_q;
  wppm_pkg::count_t               issue_left_q;
  logic                           rdata_vld_q;
  logic                           rdata_last_q;
  wppm_pkg::sample_t              lo_q;
  wppm_pkg::sample_t              hi_q;

  logic                           out_valid_q;
  wppm_pkg::sample_t              out_min_q;
  wppm_pkg::sample_t              out_max_q;
  wppm_pkg::sample_t              out_spread_q;

  logic                           in_xfer;
  logic                           wr_en;
  logic                           meas_start;
  wppm_pkg::slot_t                in_slot;
  wppm_pkg::count_t               eff_len;
  wppm_pkg::slot_t                start_slot;
  logic                           rd_en;
  wppm_pkg::sample_t              sample;
  wppm_pkg::sample_t              lo_d;
  wppm_pkg::sample_t              hi_d;
  logic                           out_free;

  // Handshakes.
  assign in_i.ready  = (state_q == ST_IDLE);
  assign cfg_i.ready = 1'b1;
  assign in_xfer     = in_i.valid && in_i.ready;
  assign wr_en       = in_xfer && (in_i.opcode == wppm_pkg::OP_WRITE);
  assign meas_start  = in_xfer && (in_i.opcode == wppm_pkg::OP_MEASURE);
  assign out_free    = !out_valid_q || out_o.ready;

  // The slot wraps modulo the depth, a mask for a power-of-two store.
  assign in_slot = in_i.position[wppm_pkg::SLOT_W-1:0];

  // Effective window length: zero counts as one, long windows clip to the depth.
  always_comb begin
    if (window_len_q == '0) begin
      eff_len = wppm_pkg::count_t'(1);
    end else if (wppm_pkg::COUNT_W'(window_len_q) > wppm_pkg::COUNT_W'(wppm_pkg::STORE_DEPTH))
    begin
      eff_len = wppm_pkg::count_t'(wppm_pkg::STORE_DEPTH);
    end else begin
      eff_len = wppm_pkg::count_t'(window_len_q);
    end
  end

  // Oldest slot of the window; the arithmetic wraps in the slot width.
  assign start_slot = in_slot - eff_len[wppm_pkg::SLOT_W-1:0] + wppm_pkg::slot_t'(1);

  assign rd_en = (state_q == ST_SCAN) && (issue_left_q != '0);

  // A slot never written since reset reads as zero.
  assign sample = rwritten_q ? rdata_q : '0;
  assign lo_d   = (sample < lo_q) ? sample : lo_q;
  assign hi_d   = (sample > hi_q) ? sample : hi_q;

  // Sample memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      sample_mem[in_slot] <= in_i.sample_value;
    end
    rdata_q <= sample_mem[rd_addr_q];
  end

  // Sequencer, valid bits, configuration and the result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      window_len_q <= wppm_pkg::LEN_RESET;
      written_q    <= '0;
      rwritten_q   <= 1'b0;
      rd_addr_q    <= '0;
      issue_left_q <= '0;
      rdata_vld_q  <= 1'b0;
      rdata_last_q <= 1'b0;
      lo_q         <= '1;
      hi_q         <= '0;
      out_valid_q  <= 1'b0;
      out_min_q    <= '0;
      out_max_q    <= '0;
      out_spread_q <= '0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        window_len_q <= cfg_i.data;
      end
      if (wr_en) begin
        written_q[in_slot] <= 1'b1;
      end
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end

      // The valid bit travels alongside the memory read data.
      rwritten_q   <= written_q[rd_addr_q];
      rdata_vld_q  <= rd_en;
      rdata_last_q <= rd_en && (issue_left_q == wppm_pkg::count_t'(1));

      unique case (state_q)
        ST_IDLE: begin
          if (meas_start) begin
            rd_addr_q    <= start_slot;
            issue_left_q <= eff_len;
            lo_q         <= '1;
            hi_q         <= '0;
            state_q      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // Issue one read per cycle until the window is covered.
          if (rd_en) begin
            rd_addr_q    <= rd_addr_q + wppm_pkg::slot_t'(1);
            issue_left_q <= issue_left_q - wppm_pkg::count_t'(1);
          end
          if (rdata_vld_q) begin
            lo_q <= lo_d;
            hi_q <= hi_d;
            if (rdata_last_q) begin
              state_q <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          // Wait until the result register is free.
          if (out_free) begin
            out_valid_q  <= 1'b1;
            out_min_q    <= lo_q;
            out_max_q    <= hi_q;
            out_spread_q <= hi_q - lo_q;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.min_level = out_min_q;
  assign out_o.max_level = out_max_q;
  assign out_o.spread    = out_spread_q;

endmodule : window_peak_to_peak_meter_unit

`default_nettype wire

>>> sv/wppm_checker.sv
// Port-level checks for the window peak-to-peak meter, bound to the top level.
// Depends on wppm_pkg and window_peak_to_peak_meter_unit.
`timescale 1ns / 1ps
`default_nettype none

module wppm_checker (
  input wire                    clk_i,
  input wire                    rst_ni,
  input wire                    in_valid_i,
  input wire                    in_ready_i,
  input wire                    in_opcode_i,
  input wire                    out_valid_i,
  input wire                    out_ready_i,
  input wire wppm_pkg::sample_t min_level_i,
  input wire wppm_pkg::sample_t max_level_i,
  input wire wppm_pkg::sample_t spread_i
);

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(min_level_i)
      && $stable(max_level_i) && $stable(spread_i))
    else $error("stalled result changed");

  // The spread is the difference of the two extremes.
  a_spread: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> spread_i == wppm_pkg::sample_t'(max_level_i - min_level_i))
    else $error("spread does not match max minus min");

  // The minimum never lies above the maximum.
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> min_level_i <= max_level_i)
    else $error("minimum above maximum");

  // A measure occupies the block while its window is scanned.
  a_measure_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_opcode_i == wppm_pkg::OP_MEASURE) |=> !in_ready_i)
    else $error("input taken during a scan");

endmodule : wppm_checker

bind window_peak_to_peak_meter_unit wppm_checker u_wppm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_opcode_i (in_i.opcode),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .min_level_i (out_o.min_level),
  .max_level_i (out_o.max_level),
  .spread_i    (out_o.spread)
);

`default_nettype wire
